// ===== sv/tsnm_pkg.sv =====
`timescale 1ns / 1ps
package tsnm_pkg;

   localparam int FRAC_BITS_DEFAULT = 14;

   // saturation bounds of a signed 16-bit component
   localparam int OUT_POS_LIMIT = 32767;
   localparam int OUT_NEG_LIMIT = 32768;
   localparam logic signed [15:0] OUT_MAX = 16'sh7fff;
   localparam logic signed [15:0] OUT_MIN = 16'sh8000;

   typedef struct packed {
      logic [23:0]        texel_rgb;
      logic               bump_on;
      logic signed [15:0] tangent_x;
      logic signed [15:0] tangent_y;
      logic signed [15:0] tangent_z;
      logic signed [15:0] bitangent_x;
      logic signed [15:0] bitangent_y;
      logic signed [15:0] bitangent_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_normal_x;
      logic signed [15:0] out_normal_y;
      logic signed [15:0] out_normal_z;
   } rsp_type;

   // per-item control that rides along the whole pipeline
   typedef struct packed {
      logic               bump;
      logic               zero;
      logic [2:0]         neg;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } side_type;

endpackage

// ===== sv/tangent_space_normal_map_unit.sv =====
`timescale 1ns / 1ps
// Tangent-space normal mapping unit. Each transfer on the request side carries a normal-map
// texel and the tangent, bitangent and normal of one hit; the unit decodes the texel, forms
// the world-space sum, normalizes it to unit length and returns one result on rsp_data,
// marked by rsp_strobe for a single cycle. The unit is a fixed pipeline that never holds:
// busy stays low and one request can be issued every clock. The depth of the pipeline
// is set mainly by the square root, which resolves one root bit per stage over 31 stages,
// and by the divider, which resolves one quotient bit per stage over FRAC_BITS + 1 stages.
// Results come out in request order and cannot be held off, so the receiver must take one
// every cycle a strobe is high. With bump_on low the input normal is returned as is; a
// zero-length sum returns a zero vector; components saturate to the signed 16-bit range.
module tangent_space_normal_map_unit #(
   parameter int FRAC_BITS = tsnm_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tsnm_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tsnm_pkg::rsp_type rsp_data
);
   import tsnm_pkg::*;

   localparam int ProdW     = 25;
   localparam int CW        = 27;
   localparam int MagW      = 25;
   localparam int SquareW   = 2 * MagW;
   localparam int SumW      = SquareW + 2;
   localparam int SqW       = 62;
   localparam int RootW     = SqW / 2;
   localparam int RemW      = RootW + 1;
   localparam int QuotW     = FRAC_BITS + 1;
   localparam int NumW      = RootW + 1 + FRAC_BITS;
   localparam int ExtW      = (QuotW > 17) ? QuotW : 17;
   localparam int NormSteps = 5;
   localparam int SqrtSteps = RootW;
   localparam int DivSteps  = QuotW;
   localparam int NormBase  = 5;
   localparam int SqrtBase  = NormBase + NormSteps;
   localparam int NumStage  = SqrtBase + SqrtSteps;
   localparam int DivBase   = NumStage + 1;
   localparam int Depth     = DivBase + DivSteps;

   // the pipeline never holds, so a request is always taken
   assign busy = 1'b0;

   // ---------------------------------------------------------------- control pipeline
   logic     vld_in  [Depth];
   logic     vld_ff  [Depth];
   side_type side_in [Depth];
   side_type side_ff [Depth];

   logic signed [ProdW-1:0]  prod_in [3][3];
   logic signed [ProdW-1:0]  prod_ff [3][3];
   logic signed [CW-1:0]     c_in  [3];
   logic signed [CW-1:0]     c_ff  [3];
   logic [MagW-1:0]          mag_in  [3];
   logic [MagW-1:0]          mag_ff  [3];
   logic [SquareW-1:0]       sq_in   [3];
   logic [SquareW-1:0]       sq_ff   [3];
   logic [MagW-1:0]          mag3_ff [3];
   logic [SumW-1:0]          sum_in;
   logic [SumW-1:0]          sum_ff;
   logic [MagW-1:0]          mag4_ff [3];

   always_comb begin
      side_in[0].bump     = req_data.bump_on;
      side_in[0].zero     = 1'b0;
      side_in[0].neg      = '0;
      side_in[0].normal_x = req_data.normal_x;
      side_in[0].normal_y = req_data.normal_y;
      side_in[0].normal_z = req_data.normal_z;
      vld_in[0]           = start & ~busy;
      for (int s = 1; s < Depth; s++) begin
         side_in[s] = side_ff[s-1];
         vld_in[s]  = vld_ff[s-1];
      end
      // sign of each sum is known after stage 1, zero length after the squares
      for (int i = 0; i < 3; i++) begin
         side_in[2].neg[i] = c_ff[i][CW-1];
      end
      side_in[4].zero = ((sq_ff[0] | sq_ff[1] | sq_ff[2]) == '0);
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < Depth; s++) begin
         side_ff[s] <= side_in[s];
      end
      if (reset) begin
         for (int s = 0; s < Depth; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s < Depth; s++) begin
            vld_ff[s] <= vld_in[s];
         end
      end
   end

   // ---------------------------------------------------------------- decode and products
   always_comb begin
      logic signed [9:0]  m  [3];
      logic signed [15:0] tv [3];
      logic signed [15:0] bv [3];
      logic signed [15:0] nv [3];
      m[0]  = $signed({1'b0, req_data.texel_rgb[23:16], 1'b0}) - 10'sd255;
      m[1]  = $signed({1'b0, req_data.texel_rgb[15:8], 1'b0}) - 10'sd255;
      m[2]  = $signed({1'b0, req_data.texel_rgb[7:0], 1'b0}) - 10'sd255;
      tv[0] = req_data.tangent_x;
      tv[1] = req_data.tangent_y;
      tv[2] = req_data.tangent_z;
      bv[0] = req_data.bitangent_x;
      bv[1] = req_data.bitangent_y;
      bv[2] = req_data.bitangent_z;
      nv[0] = req_data.normal_x;
      nv[1] = req_data.normal_y;
      nv[2] = req_data.normal_z;
      for (int i = 0; i < 3; i++) begin
         prod_in[i][0] = ProdW'(tv[i]) * ProdW'(m[0]);
         prod_in[i][1] = ProdW'(bv[i]) * ProdW'(m[1]);
         prod_in[i][2] = ProdW'(nv[i]) * ProdW'(m[2]);
      end
   end

   // ---------------------------------------------------------------- sums, magnitudes, squares
   always_comb begin
      logic signed [CW-1:0] abs_c;
      for (int i = 0; i < 3; i++) begin
         c_in[i] = CW'(prod_ff[i][0]) + CW'(prod_ff[i][1]) + CW'(prod_ff[i][2]);
         abs_c     = c_ff[i][CW-1] ? -c_ff[i] : c_ff[i];
         mag_in[i] = abs_c[MagW-1:0];
         sq_in[i]  = SquareW'(mag_ff[i]) * SquareW'(mag_ff[i]);
      end
      sum_in = SumW'(sq_ff[0]) + SumW'(sq_ff[1]) + SumW'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[i][j] <= prod_in[i][j];
         end
         c_ff[i]    <= c_in[i];
         mag_ff[i]  <= mag_in[i];
         sq_ff[i]   <= sq_in[i];
         mag3_ff[i] <= mag_ff[i];
         mag4_ff[i] <= mag3_ff[i];
      end
      sum_ff <= sum_in;
   end

   // ---------------------------------------------------------------- normalize by pairs of bits
   logic [SqW-1:0]   sh_in [NormSteps];
   logic [SqW-1:0]   sh_ff [NormSteps];
   logic [RootW-1:0] av_in [NormSteps][3];
   logic [RootW-1:0] av_ff [NormSteps][3];

   for (genvar k = 0; k < NormSteps; k++) begin : g_norm
      localparam int Pairs = 1 << (NormSteps - 1 - k);
      logic [SqW-1:0]   sh_src;
      logic [RootW-1:0] a_src [3];

      if (k == 0) begin : g_src
         always_comb begin
            sh_src = SqW'(sum_ff);
            for (int i = 0; i < 3; i++) begin
               a_src[i] = RootW'(mag4_ff[i]);
            end
         end
      end else begin : g_src
         always_comb begin
            sh_src = sh_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               a_src[i] = av_ff[k-1][i];
            end
         end
      end

      // the magnitudes take half the shift of the sum of squares
      always_comb begin
         if (sh_src[SqW-1 -: 2*Pairs] == '0) begin
            sh_in[k] = sh_src << (2 * Pairs);
            for (int i = 0; i < 3; i++) begin
               av_in[k][i] = a_src[i] << Pairs;
            end
         end else begin
            sh_in[k] = sh_src;
            for (int i = 0; i < 3; i++) begin
               av_in[k][i] = a_src[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         sh_ff[k] <= sh_in[k];
         for (int i = 0; i < 3; i++) begin
            av_ff[k][i] <= av_in[k][i];
         end
      end
   end

   // ---------------------------------------------------------------- square root, one bit a stage
   logic [RemW-1:0]  rem_in  [SqrtSteps];
   logic [RemW-1:0]  rem_ff  [SqrtSteps];
   logic [RootW-1:0] root_in [SqrtSteps];
   logic [RootW-1:0] root_ff [SqrtSteps];
   logic [SqW-1:0]   xs_in   [SqrtSteps];
   logic [SqW-1:0]   xs_ff   [SqrtSteps];
   logic [RootW-1:0] as_ff   [SqrtSteps][3];

   for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
      logic [RemW-1:0]  rem_src;
      logic [RootW-1:0] root_src;
      logic [SqW-1:0]   x_src;
      logic [RootW-1:0] a_src [3];

      if (j == 0) begin : g_src
         always_comb begin
            rem_src  = '0;
            root_src = '0;
            x_src    = sh_ff[NormSteps-1];
            for (int i = 0; i < 3; i++) begin
               a_src[i] = av_ff[NormSteps-1][i];
            end
         end
      end else begin : g_src
         always_comb begin
            rem_src  = rem_ff[j-1];
            root_src = root_ff[j-1];
            x_src    = xs_ff[j-1];
            for (int i = 0; i < 3; i++) begin
               a_src[i] = as_ff[j-1][i];
            end
         end
      end

      always_comb begin
         logic [RemW+1:0] trial;
         logic [RemW+1:0] cur;
         logic [RemW+1:0] diff;
         cur   = {rem_src, x_src[SqW-1 -: 2]};
         trial = {1'b0, root_src, 2'b01};
         diff  = cur - trial;
         if (cur >= trial) begin
            rem_in[j]  = diff[RemW-1:0];
            root_in[j] = {root_src[RootW-2:0], 1'b1};
         end else begin
            rem_in[j]  = cur[RemW-1:0];
            root_in[j] = {root_src[RootW-2:0], 1'b0};
         end
         xs_in[j] = x_src << 2;
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in[j];
         root_ff[j] <= root_in[j];
         xs_ff[j]   <= xs_in[j];
         for (int i = 0; i < 3; i++) begin
            as_ff[j][i] <= a_src[i];
         end
      end
   end

   // ---------------------------------------------------------------- dividend with rounding term
   logic [NumW-1:0]  num_in [3];
   logic [NumW-1:0]  num_ff [3];
   logic [RootW-1:0] qn_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (NumW'(as_ff[SqrtSteps-1][i]) << FRAC_BITS)
                   + NumW'(root_ff[SqrtSteps-1] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         num_ff[i] <= num_in[i];
      end
      qn_ff <= root_ff[SqrtSteps-1];
   end

   // ---------------------------------------------------------------- restoring divide, one bit a stage
   // the dividend's upper part is always below the root, so only QuotW bits remain
   logic [RootW-1:0] dr_in   [DivSteps][3];
   logic [RootW-1:0] dr_ff   [DivSteps][3];
   logic [QuotW-1:0] low_in  [DivSteps][3];
   logic [QuotW-1:0] low_ff  [DivSteps][3];
   logic [QuotW-1:0] quot_in [DivSteps][3];
   logic [QuotW-1:0] quot_ff [DivSteps][3];
   logic [RootW-1:0] dq_ff   [DivSteps];

   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      logic [RootW-1:0] r_src [3];
      logic [QuotW-1:0] l_src [3];
      logic [QuotW-1:0] q_src [3];
      logic [RootW-1:0] d_src;

      if (k == 0) begin : g_src
         always_comb begin
            d_src = qn_ff;
            for (int i = 0; i < 3; i++) begin
               r_src[i] = num_ff[i][NumW-1:QuotW];
               l_src[i] = num_ff[i][QuotW-1:0];
               q_src[i] = '0;
            end
         end
      end else begin : g_src
         always_comb begin
            d_src = dq_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               r_src[i] = dr_ff[k-1][i];
               l_src[i] = low_ff[k-1][i];
               q_src[i] = quot_ff[k-1][i];
            end
         end
      end

      always_comb begin
         logic [RootW:0] cur;
         logic [RootW:0] diff;
         logic           ge;
         for (int i = 0; i < 3; i++) begin
            cur  = {r_src[i], l_src[i][QuotW-1]};
            diff = cur - {1'b0, d_src};
            ge   = (cur >= {1'b0, d_src});
            dr_in[k][i]   = ge ? diff[RootW-1:0] : cur[RootW-1:0];
            low_in[k][i]  = l_src[i] << 1;
            quot_in[k][i] = {q_src[i][QuotW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         dq_ff[k] <= d_src;
         for (int i = 0; i < 3; i++) begin
            dr_ff[k][i]   <= dr_in[k][i];
            low_ff[k][i]  <= low_in[k][i];
            quot_ff[k][i] <= quot_in[k][i];
         end
      end
   end

   // ---------------------------------------------------------------- sign, saturation, bypass
   logic    rsp_strobe_in;
   logic    rsp_strobe_ff;
   rsp_type rsp_data_in;
   rsp_type rsp_data_ff;

   always_comb begin
      logic [ExtW-1:0]    mag_r;
      logic signed [15:0] val [3];
      side_type           sd;
      sd = side_ff[Depth-1];
      for (int i = 0; i < 3; i++) begin
         mag_r = ExtW'(quot_ff[DivSteps-1][i]);
         if (sd.neg[i]) begin
            val[i] = (mag_r > ExtW'(OUT_NEG_LIMIT)) ? OUT_MIN : -$signed(mag_r[15:0]);
         end else begin
            val[i] = (mag_r > ExtW'(OUT_POS_LIMIT)) ? OUT_MAX : $signed(mag_r[15:0]);
         end
      end
      if (!sd.bump) begin
         rsp_data_in.out_normal_x = sd.normal_x;
         rsp_data_in.out_normal_y = sd.normal_y;
         rsp_data_in.out_normal_z = sd.normal_z;
      end else if (sd.zero) begin
         rsp_data_in.out_normal_x = '0;
         rsp_data_in.out_normal_y = '0;
         rsp_data_in.out_normal_z = '0;
      end else begin
         rsp_data_in.out_normal_x = val[0];
         rsp_data_in.out_normal_y = val[1];
         rsp_data_in.out_normal_z = val[2];
      end
      rsp_strobe_in = vld_ff[Depth-1];
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
